// ===== rtl/core/arma_pkg.sv =====
// ----------------------------------------------------------------------------
// arma_pkg
// Shared types and constants of the ARMA filter: item layouts, coefficient
// register indexes, sequencer step codes and accumulator sizing.
// ----------------------------------------------------------------------------
package arma_pkg;

  localparam int SampleW  = 16;
  localparam int CoefW    = 16;
  localparam int ProdW    = SampleW + CoefW;
  // seven products of at most 2^30 in magnitude fit in 34 bits, keep one spare
  localparam int AccW     = ProdW + 3;
  localparam int NumRegs  = 7;
  localparam int HistD    = 3;
  localparam int RoundSh  = 12;
  localparam int RegIdxW  = 3;
  localparam int StepW    = 3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic [RegIdxW-1:0]        reg_idx_t;
  typedef logic [StepW-1:0]          step_t;

  // register indexes in the configuration map
  localparam reg_idx_t RegAr1 = 3'd0;
  localparam reg_idx_t RegAr2 = 3'd1;
  localparam reg_idx_t RegAr3 = 3'd2;
  localparam reg_idx_t RegMa0 = 3'd3;
  localparam reg_idx_t RegMa1 = 3'd4;
  localparam reg_idx_t RegMa2 = 3'd5;
  localparam reg_idx_t RegMa3 = 3'd6;

  localparam coef_t MaCoef0Rst = 16'sd4096;

  // multiply-accumulate steps: current noise, three noise lags, three output lags
  localparam step_t StepW0  = 3'd0;
  localparam step_t StepW1  = 3'd1;
  localparam step_t StepW2  = 3'd2;
  localparam step_t StepW3  = 3'd3;
  localparam step_t StepX1  = 3'd4;
  localparam step_t StepX2  = 3'd5;
  localparam step_t StepX3  = 3'd6;
  localparam step_t LastStep = StepX3;

  typedef struct packed {
    sample_t noise_sample;
    logic    start_of_sequence;
    logic    end_of_sequence;
  } in_item_t;

  typedef struct packed {
    sample_t out_sample;
    logic    out_last;
  } out_item_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic  clr;     // clear accumulator, latch item
    logic  issue;   // feed one operand pair into the multiplier
    step_t step;    // which product is issued
    logic  finish;  // round, saturate, update delay lines, load result
  } ctrl_t;

endpackage

// ===== rtl/core/arma_in_if.sv =====
// ----------------------------------------------------------------------------
// arma_in_if
// Valid/ready channel carrying one noise item into the ARMA filter.
// ----------------------------------------------------------------------------
interface arma_in_if;
  logic               valid;
  logic               ready;
  arma_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/arma_out_if.sv =====
// ----------------------------------------------------------------------------
// arma_out_if
// Valid/ready channel carrying one filtered result item out of the filter.
// ----------------------------------------------------------------------------
interface arma_out_if;
  logic                valid;
  logic                ready;
  arma_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/arma_mac.sv =====
// ----------------------------------------------------------------------------
// arma_mac
// Shared multiply-accumulate unit: registered 16x16 product, then a signed
// add or subtract into the wide accumulator.
// ----------------------------------------------------------------------------
module arma_mac (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             en_i,
  input  logic             sub_i,
  input  arma_pkg::coef_t  coef_i,
  input  arma_pkg::sample_t smp_i,
  output arma_pkg::acc_t   acc_o
);

  arma_pkg::prod_t prod_q;
  logic            vld_q, vld_d;
  logic            sub_q;
  arma_pkg::acc_t  acc_q, acc_d;
  arma_pkg::acc_t  term;

  assign vld_d = en_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= arma_pkg::prod_t'(coef_i) * arma_pkg::prod_t'(smp_i);
    sub_q  <= sub_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    term = arma_pkg::acc_t'(prod_q);
    if (sub_q) begin
      term = -term;
    end
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (vld_q) begin
      acc_d = acc_q + term;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/core/arma_ctrl.sv =====
// ----------------------------------------------------------------------------
// arma_ctrl
// Sequencer of the filter: steps the shared MAC through seven products,
// waits for the last one to land, then finishes the item.
// ----------------------------------------------------------------------------
module arma_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_free_i,
  output logic            idle_o,
  output arma_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StMac   = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  arma_pkg::step_t step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ctrl_o  = '0;
    ctrl_o.step = step_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          ctrl_o.clr = 1'b1;
          step_d     = arma_pkg::StepW0;
          state_d    = StMac;
        end
      end
      StMac: begin
        ctrl_o.issue = 1'b1;
        if (step_q == arma_pkg::LastStep) begin
          state_d = StDrain;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      StDrain: begin
        // last product accumulates this cycle
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register can take the result
        if (out_free_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign idle_o = (state_q == StIdle);

endmodule

// ===== rtl/core/arma_filter.sv =====
// ----------------------------------------------------------------------------
// arma_filter
// Fixed-point direct-form ARMA(3,3) filter around one shared multiplier.
// ----------------------------------------------------------------------------
// A noise item is accepted only once the previous one is finished: the single
// shared multiply-accumulate unit forms the seven coefficient products, a
// drain step lets the last registered product reach the accumulator, a
// finish step rounds, saturates and shifts the delay lines, and idle accepts.
// The result sits in an output register, so the next item is accepted while it
// waits; the finish step stalls only while that register is still full.
// start_of_sequence clears both delay lines before the item is used. The user must
// write coefficients through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the
// block does not enforce it. Indexes beyond the seven registers are ignored.
module arma_filter #(
  parameter int AR_ORDER = 3,
  parameter int MA_ORDER = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  arma_pkg::reg_idx_t   cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  arma_in_if.sink              in_i,
  arma_out_if.source           out_o
);

  arma_pkg::coef_t   coef_q [arma_pkg::NumRegs];
  arma_pkg::sample_t nhist_q [arma_pkg::HistD];
  arma_pkg::sample_t ohist_q [arma_pkg::HistD];
  arma_pkg::sample_t w_q;
  logic              last_q;
  logic              out_valid_q;
  arma_pkg::out_item_t out_data_q;

  arma_pkg::ctrl_t   ctrl;
  logic              idle;
  logic              in_fire;
  logic              out_free;
  arma_pkg::acc_t    acc;

  arma_pkg::coef_t   op_coef;
  arma_pkg::sample_t op_smp;
  logic              op_sub;

  logic signed [arma_pkg::AccW:0]              biased;
  logic signed [arma_pkg::AccW-arma_pkg::RoundSh:0] rounded;
  arma_pkg::sample_t sat;

  assign in_i.ready = idle;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  arma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .idle_o     (idle),
    .ctrl_o     (ctrl)
  );

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < arma_pkg::NumRegs; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[arma_pkg::RegMa0] <= arma_pkg::MaCoef0Rst;
    end else if (cfg_we_i && (cfg_idx_i <= arma_pkg::RegMa3)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // operand select; lags beyond the configured orders read a zero coefficient
  always_comb begin
    op_coef = '0;
    op_smp  = '0;
    op_sub  = 1'b0;
    unique case (ctrl.step)
      arma_pkg::StepW0: begin
        op_coef = coef_q[arma_pkg::RegMa0];
        op_smp  = w_q;
      end
      arma_pkg::StepW1: begin
        op_coef = (MA_ORDER >= 1) ? coef_q[arma_pkg::RegMa1] : '0;
        op_smp  = nhist_q[0];
      end
      arma_pkg::StepW2: begin
        op_coef = (MA_ORDER >= 2) ? coef_q[arma_pkg::RegMa2] : '0;
        op_smp  = nhist_q[1];
      end
      arma_pkg::StepW3: begin
        op_coef = (MA_ORDER >= 3) ? coef_q[arma_pkg::RegMa3] : '0;
        op_smp  = nhist_q[2];
      end
      arma_pkg::StepX1: begin
        op_coef = (AR_ORDER >= 1) ? coef_q[arma_pkg::RegAr1] : '0;
        op_smp  = ohist_q[0];
        op_sub  = 1'b1;
      end
      arma_pkg::StepX2: begin
        op_coef = (AR_ORDER >= 2) ? coef_q[arma_pkg::RegAr2] : '0;
        op_smp  = ohist_q[1];
        op_sub  = 1'b1;
      end
      arma_pkg::StepX3: begin
        op_coef = (AR_ORDER >= 3) ? coef_q[arma_pkg::RegAr3] : '0;
        op_smp  = ohist_q[2];
        op_sub  = 1'b1;
      end
      default: begin
        op_coef = '0;
      end
    endcase
  end

  arma_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (ctrl.clr),
    .en_i   (ctrl.issue),
    .sub_i  (op_sub),
    .coef_i (op_coef),
    .smp_i  (op_smp),
    .acc_o  (acc)
  );

  // round half up to Q1.15, then saturate
  always_comb begin
    biased  = (arma_pkg::AccW+1)'(acc) + (arma_pkg::AccW+1)'(2048);
    rounded = biased[arma_pkg::AccW:arma_pkg::RoundSh];
    if (rounded > 32767) begin
      sat = 16'sh7fff;
    end else if (rounded < -32768) begin
      sat = 16'sh8000;
    end else begin
      sat = rounded[15:0];
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      w_q    <= in_i.data.noise_sample;
      last_q <= in_i.data.end_of_sequence;
    end
  end

  // delay lines: clear on start of sequence, advance on finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < arma_pkg::HistD; i++) begin
        nhist_q[i] <= '0;
        ohist_q[i] <= '0;
      end
    end else if (in_fire && in_i.data.start_of_sequence) begin
      for (int i = 0; i < arma_pkg::HistD; i++) begin
        nhist_q[i] <= '0;
        ohist_q[i] <= '0;
      end
    end else if (ctrl.finish) begin
      for (int i = arma_pkg::HistD - 1; i > 0; i--) begin
        nhist_q[i] <= nhist_q[i-1];
        ohist_q[i] <= ohist_q[i-1];
      end
      nhist_q[0] <= w_q;
      ohist_q[0] <= sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_data_q.out_sample <= sat;
      out_data_q.out_last   <= last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // no second item enters while one is in the MAC
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input accepted while an item was in progress");

  // a new result appears only from a finish step
  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !$past(out_o.valid)) |-> $past(ctrl.finish))
    else $error("result appeared without a finish step");

  // finish never overwrites a result that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> (!out_valid_q || out_o.ready))
    else $error("finish overwrote a pending result");

  // issue steps stay within the seven products
  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.issue |-> (ctrl.step <= arma_pkg::LastStep))
    else $error("MAC step out of range");

endmodule
